// ===== rtl/core/lz77_window_expander_assert.svh =====
// assertion macros for the lz77 window expander
// depends on nothing; taken in by the top level with an include
`ifndef LZ77_WINDOW_EXPANDER_ASSERT_SVH
`define LZ77_WINDOW_EXPANDER_ASSERT_SVH

// same-cycle implication, held off during reset
`define LZWE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lz77 window expander: same-cycle check failed");

// next-cycle implication, held off during reset
`define LZWE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lz77 window expander: next-cycle check failed");

`endif

// ===== rtl/core/lzwe_pkg.sv =====
// shared types and constants for the lz77 window expander
// no dependencies
package lzwe_pkg;

	localparam int WINDOW_SIZE_DEF = 8192;
	localparam int MIN_MATCH_DEF   = 3;
	localparam int MAX_MATCH_DEF   = 256;

	localparam int CODE_W  = 9;
	localparam int DIST_W  = 13;
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 3;
	localparam int LANES   = 4;

	// largest code that is a plain literal byte
	localparam logic [CODE_W-1:0] LITERAL_MAX = 9'd255;
	// first match code, before the minimum length is added back
	localparam int CODE_BASE = 256;

	// window port strobes from the sequencer
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} win_ctl_t;

endpackage

// ===== rtl/core/lzwe_ifs.sv =====
// valid/ready channel interfaces for symbols in and packed bytes out
// depends on lzwe_pkg
interface lzwe_sym_if;
	logic                          valid;
	logic                          ready;
	logic [lzwe_pkg::CODE_W-1:0]   symbol_code;
	logic [lzwe_pkg::DIST_W-1:0]   match_distance;

	modport source (output valid, symbol_code, match_distance, input ready);
	modport sink   (input valid, symbol_code, match_distance, output ready);
endinterface

interface lzwe_res_if;
	logic                          valid;
	logic                          ready;
	logic [lzwe_pkg::BYTE_W-1:0]   byte_a;
	logic [lzwe_pkg::BYTE_W-1:0]   byte_b;
	logic [lzwe_pkg::BYTE_W-1:0]   byte_c;
	logic [lzwe_pkg::BYTE_W-1:0]   byte_d;
	logic [lzwe_pkg::COUNT_W-1:0]  byte_count;
	logic                          last_of_run;

	modport source (output valid, byte_a, byte_b, byte_c, byte_d, byte_count, last_of_run,
		input ready);
	modport sink   (input valid, byte_a, byte_b, byte_c, byte_d, byte_count, last_of_run,
		output ready);
endinterface

// ===== rtl/core/lzwe_window.sv =====
// history ring: one write and one registered read per cycle, fill count, bypass
// depends on lzwe_pkg
module lzwe_window #(
	parameter int WINDOW_SIZE = lzwe_pkg::WINDOW_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lzwe_pkg::win_ctl_t            ctl,
	input  logic [$clog2(WINDOW_SIZE)-1:0] rd_addr,
	input  logic [$clog2(WINDOW_SIZE)-1:0] wr_addr,
	input  logic [lzwe_pkg::BYTE_W-1:0]   wr_data,
	output logic [lzwe_pkg::BYTE_W-1:0]   rd_byte
);

	localparam int AW = $clog2(WINDOW_SIZE);

	logic [lzwe_pkg::BYTE_W-1:0] mem [WINDOW_SIZE];
	logic [lzwe_pkg::BYTE_W-1:0] mem_q;
	logic [lzwe_pkg::BYTE_W-1:0] fwd_data_q;
	logic                        fwd_q;
	logic                        written_q;
	logic [AW:0]                 fill_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			mem_q <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// entries below the fill count have been written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			fwd_q <= 1'b0;
			written_q <= 1'b0;
		end else begin
			if (ctl.wr_en && (fill_q != (AW+1)'(WINDOW_SIZE))) begin
				fill_q <= fill_q + (AW+1)'(1);
			end
			if (ctl.rd_en) begin
				fwd_q <= ctl.wr_en && (rd_addr == wr_addr);
				written_q <= ({1'b0, rd_addr} < fill_q);
			end
		end
	end

	assign rd_byte = fwd_q ? fwd_data_q : (written_q ? mem_q : '0);

endmodule

// ===== rtl/core/lzwe_seq.sv =====
// copy sequencer: pointers, length count, lane packing and output register
// depends on lzwe_pkg and the channel interfaces
module lzwe_seq #(
	parameter int WINDOW_SIZE = lzwe_pkg::WINDOW_SIZE_DEF,
	parameter int MIN_MATCH   = lzwe_pkg::MIN_MATCH_DEF,
	parameter int MAX_MATCH   = lzwe_pkg::MAX_MATCH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	lzwe_sym_if.sink                       symbols,
	lzwe_res_if.source                     results,
	output lzwe_pkg::win_ctl_t             win_ctl,
	output logic [$clog2(WINDOW_SIZE)-1:0] rd_addr,
	output logic [$clog2(WINDOW_SIZE)-1:0] wr_addr,
	output logic [lzwe_pkg::BYTE_W-1:0]    wr_data,
	input  logic [lzwe_pkg::BYTE_W-1:0]    win_byte
);

	localparam int AW = $clog2(WINDOW_SIZE);
	localparam int LW = $clog2(MAX_MATCH + 1);
	localparam int SW = (AW > lzwe_pkg::DIST_W) ? AW : lzwe_pkg::DIST_W;
	localparam int XW = lzwe_pkg::CODE_W + 1;
	localparam int BW = lzwe_pkg::BYTE_W;

	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [LW-1:0] left_q;

	logic          valid_s1;
	logic          lit_s1;
	logic          last_s1;
	logic [BW-1:0] lit_byte_s1;

	logic [BW-1:0] pack_q [lzwe_pkg::LANES];
	logic [1:0]    cnt_q;

	logic          out_valid_q;
	logic [BW-1:0] out_lane_q [lzwe_pkg::LANES];
	logic [lzwe_pkg::COUNT_W-1:0] out_count_q;
	logic          out_last_q;

	logic          accept;
	logic          is_lit;
	logic [XW-1:0] len_full;
	logic [LW-1:0] len;
	logic [SW-1:0] start_full;
	logic          issue;
	logic          consume;
	logic          need_push;
	logic          can_take;
	logic [BW-1:0] byte_s1;
	logic [BW-1:0] lanes_nxt [lzwe_pkg::LANES];

	assign symbols.ready = (left_q == '0) && !valid_s1;
	assign accept = symbols.valid && symbols.ready;
	assign is_lit = symbols.symbol_code <= lzwe_pkg::LITERAL_MAX;

	// match length, clipped at the longest copy
	assign len_full = {1'b0, symbols.symbol_code} - XW'(lzwe_pkg::CODE_BASE - MIN_MATCH);
	assign len = (len_full > XW'(MAX_MATCH)) ? LW'(MAX_MATCH) : len_full[LW-1:0];
	assign start_full = SW'(wp_q) - SW'(symbols.match_distance) - SW'(1);

	assign byte_s1 = lit_s1 ? lit_byte_s1 : win_byte;
	assign need_push = (cnt_q == 2'd3) || last_s1;
	assign can_take = !need_push || !out_valid_q || results.ready;
	assign consume = valid_s1 && can_take;
	assign issue = (left_q != '0) && (!valid_s1 || consume);

	assign win_ctl.rd_en = issue;
	assign win_ctl.wr_en = consume;
	assign rd_addr = rp_q;
	assign wr_addr = wp_q;
	assign wr_data = byte_s1;

	always_comb begin
		for (int i = 0; i < lzwe_pkg::LANES; i++) begin
			lanes_nxt[i] = pack_q[i];
		end
		lanes_nxt[cnt_q] = byte_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			left_q <= '0;
			valid_s1 <= 1'b0;
			lit_s1 <= 1'b0;
			last_s1 <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < lzwe_pkg::LANES; i++) begin
				pack_q[i] <= '0;
			end
		end else begin
			if (accept && is_lit) begin
				valid_s1 <= 1'b1;
				lit_s1 <= 1'b1;
				last_s1 <= 1'b1;
			end else if (accept) begin
				left_q <= len;
				rp_q <= start_full[AW-1:0];
			end else if (issue) begin
				valid_s1 <= 1'b1;
				lit_s1 <= 1'b0;
				last_s1 <= (left_q == LW'(1));
				left_q <= left_q - LW'(1);
				rp_q <= rp_q + AW'(1);
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end

			if (consume) begin
				wp_q <= wp_q + AW'(1);
				if (need_push) begin
					cnt_q <= '0;
					for (int i = 0; i < lzwe_pkg::LANES; i++) begin
						pack_q[i] <= '0;
					end
				end else begin
					cnt_q <= cnt_q + 2'd1;
					pack_q[cnt_q] <= byte_s1;
				end
			end

			if (consume && need_push) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_lit) begin
			lit_byte_s1 <= symbols.symbol_code[BW-1:0];
		end
		if (consume && need_push) begin
			for (int i = 0; i < lzwe_pkg::LANES; i++) begin
				out_lane_q[i] <= lanes_nxt[i];
			end
			out_count_q <= {1'b0, cnt_q} + lzwe_pkg::COUNT_W'(1);
			out_last_q <= last_s1;
		end
	end

	assign results.valid = out_valid_q;
	assign results.byte_a = out_lane_q[0];
	assign results.byte_b = out_lane_q[1];
	assign results.byte_c = out_lane_q[2];
	assign results.byte_d = out_lane_q[3];
	assign results.byte_count = out_count_q;
	assign results.last_of_run = out_last_q;

endmodule

// ===== rtl/core/lz77_window_expander.sv =====
// top level of the lz77 window expander: sequencer plus history ring
// depends on lzwe_pkg, the channel interfaces, lzwe_seq, lzwe_window and the assertion header
//
// expands decoded lzss symbols through a ring history of WINDOW_SIZE bytes. a code up to
// 255 is a literal byte; a larger code copies code - (256 - MIN_MATCH) bytes (clipped at
// MAX_MATCH) starting match_distance + 1 bytes back, one byte at a time, so an overlapping
// copy repeats recent bytes. bytes leave packed up to four per word, unused lanes zero, and
// last_of_run marks the final word of each symbol. the symbol port stays busy until the last
// byte of a literal or a match has passed, since every byte goes through the single read and
// write port pair of the ring at one byte per cycle, unless back-pressure holds the output register full.
// the port takes a new symbol while the last word still waits in the output register. the ring
// needs no clearing pass after reset: a fill count makes never-written entries read as zero.
module lz77_window_expander #(
	parameter int WINDOW_SIZE = lzwe_pkg::WINDOW_SIZE_DEF,
	parameter int MIN_MATCH   = lzwe_pkg::MIN_MATCH_DEF,
	parameter int MAX_MATCH   = lzwe_pkg::MAX_MATCH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lzwe_sym_if.sink   symbols,
	lzwe_res_if.source results
);

	localparam int AW = $clog2(WINDOW_SIZE);

	// ring port strobes and addresses from the sequencer
	lzwe_pkg::win_ctl_t          win_ctl;
	logic [AW-1:0]               rd_addr;
	logic [AW-1:0]               wr_addr;
	logic [lzwe_pkg::BYTE_W-1:0] wr_data;
	// byte from the registered read of the ring, already bypassed and zero-masked
	logic [lzwe_pkg::BYTE_W-1:0] win_byte;

	lzwe_seq #(
		.WINDOW_SIZE (WINDOW_SIZE),
		.MIN_MATCH   (MIN_MATCH),
		.MAX_MATCH   (MAX_MATCH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.symbols  (symbols),
		.results  (results),
		.win_ctl  (win_ctl),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.win_byte (win_byte)
	);

	lzwe_window #(
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (win_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_byte (win_byte)
	);

`include "lz77_window_expander_assert.svh"

	// a symbol keeps the port busy for at least the cycle after it is taken
	`LZWE_ASSERT_NEXT(a_busy_after_take, clk, arst_n, symbols.valid && symbols.ready, !symbols.ready)
	// a short word can only close a run
	`LZWE_ASSERT_NOW(a_short_is_last, clk, arst_n, results.valid && (results.byte_count != 3'd4), results.last_of_run)
	// every word carries one to four bytes
	`LZWE_ASSERT_NOW(a_count_range, clk, arst_n, results.valid, (results.byte_count != 3'd0) && (results.byte_count <= 3'd4))

endmodule
